// ----- hw/rtl/rgp_pkg.sv -----
// Shared types and constants for the ray / ground plane hit block.
// Used by every module under hw/rtl; no dependencies of its own.
`default_nettype none

package rgp_pkg;

  // Coordinate fraction bits (Q16.16 by default)
  localparam int COORD_FRAC_BITS = 16;
  localparam int unsigned FRAC_MASK = (1 << COORD_FRAC_BITS) - 1;

  localparam int COORD_W   = 32;
  localparam int T_W       = 31;                      // saturated ray parameter
  localparam int REM_W     = COORD_W + COORD_FRAC_BITS;
  localparam int DIV_CMP_W = COORD_W + T_W;
  localparam int DIV_STEPS = T_W;                     // one quotient bit per stage
  localparam int ABS_W     = COORD_W - COORD_FRAC_BITS; // |floor| in whole units
  localparam int MOD_STEPS = ABS_W - 1;
  localparam int SQ_W      = 13;
  localparam int PER_W     = SQ_W + 1;                // twice the square size
  localparam int MOD_CMP_W = ABS_W + PER_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKER_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE      = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                      hit;
    logic [T_W-1:0]            hit_distance;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_z;
    logic                      material_select;
  } result_t;

  // What rides along the divider
  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_z;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic [REM_W-1:0]   rem;
    logic [T_W-1:0]     quo;
    logic               ovf;
    logic [COORD_W-1:0] den;
    side_t              side;
  } div_stage_t;

  typedef struct packed {
    logic                      valid;
    logic                      hit;
    logic                      en;
    logic [T_W-1:0]            t;
    logic signed [COORD_W-1:0] hx;
    logic signed [COORD_W-1:0] hz;
    logic [ABS_W-1:0]          ax;
    logic [ABS_W-1:0]          az;
    logic [PER_W-1:0]          per;
  } chk_stage_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rgp_div.sv -----
// Pipelined restoring divider: t = (num << F) / den, saturated to 31 bits.
// One quotient bit per stage; depends on rgp_pkg.
`default_nettype none

module rgp_div
  import rgp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [COORD_W-1:0] num,
  input  wire logic [COORD_W-1:0] den,
  input  wire side_t              in_side,
  output logic                    out_valid,
  output logic [T_W-1:0]          t,
  output side_t                   out_side
);

  div_stage_t stg [0:DIV_STEPS];

  logic [DIV_CMP_W-1:0] rem0_w;
  logic                 ovf0;

  // quotient of 2^31 or more saturates; the rest of the steps then stay in range
  assign rem0_w = DIV_CMP_W'({num, {COORD_FRAC_BITS{1'b0}}});
  assign ovf0   = rem0_w >= (DIV_CMP_W'(den) << T_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else begin
      stg[0].valid <= in_valid;
    end
    stg[0].rem  <= {num, {COORD_FRAC_BITS{1'b0}}};
    stg[0].quo  <= '0;
    stg[0].ovf  <= ovf0;
    stg[0].den  <= den;
    stg[0].side <= in_side;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    localparam int BIT = DIV_STEPS - k;
    logic [DIV_CMP_W-1:0] trial;
    logic [DIV_CMP_W-1:0] rem_ext;
    logic                 take;
    logic [T_W-1:0]       quo_next;

    assign trial   = DIV_CMP_W'(stg[k-1].den) << BIT;
    assign rem_ext = DIV_CMP_W'(stg[k-1].rem);
    assign take    = rem_ext >= trial;

    always_comb begin
      quo_next      = stg[k-1].quo;
      quo_next[BIT] = take;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k].valid <= 1'b0;
      end else begin
        stg[k].valid <= stg[k-1].valid;
      end
      stg[k].rem  <= take ? REM_W'(rem_ext - trial) : stg[k-1].rem;
      stg[k].quo  <= quo_next;
      stg[k].ovf  <= stg[k-1].ovf;
      stg[k].den  <= stg[k-1].den;
      stg[k].side <= stg[k-1].side;
    end
  end

  assign out_valid = stg[DIV_STEPS].valid;
  assign t         = stg[DIV_STEPS].ovf ? {T_W{1'b1}} : stg[DIV_STEPS].quo;
  assign out_side  = stg[DIV_STEPS].side;

endmodule

`default_nettype wire

// ----- hw/rtl/rgp_advance.sv -----
// One axis of the hit point: org + floor(dir * t / 2^F), saturated to 32 bits.
// Two stages: multiply, then round/add/saturate. Depends on rgp_pkg.
`default_nettype none

module rgp_advance
  import rgp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [COORD_W-1:0] org,
  input  wire logic signed [COORD_W-1:0] dir,
  input  wire logic [T_W-1:0]            t,
  output logic signed [COORD_W-1:0]      pos
);

  localparam int PROD_W = COORD_W + T_W;

  logic [COORD_W-1:0]        abs_dir;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         prod_q;
  logic                      neg_q;
  logic signed [COORD_W-1:0] org_q;

  logic [PROD_W-1:0]         rnd;
  logic [PROD_W-1:0]         step;
  logic signed [63:0]        step_s;
  logic signed [63:0]        org_ext;
  logic signed [63:0]        sum;
  logic signed [COORD_W-1:0] sat;

  assign abs_dir = dir[COORD_W-1] ? COORD_W'(-dir) : COORD_W'(dir);
  assign prod    = PROD_W'(abs_dir) * PROD_W'(t);

  always_ff @(posedge clk) begin
    prod_q <= prod;
    neg_q  <= dir[COORD_W-1];
    org_q  <= org;
  end

  // negative direction: magnitude rounds up so the signed step floors
  assign rnd     = neg_q ? prod_q + PROD_W'(FRAC_MASK) : prod_q;
  assign step    = rnd >> COORD_FRAC_BITS;
  assign step_s  = signed'(64'(step));
  assign org_ext = 64'(org_q);
  assign sum     = neg_q ? org_ext - step_s : org_ext + step_s;

  always_comb begin
    if (sum > 64'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -64'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = signed'(sum[COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    pos <= sat;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rgp_checker.sv -----
// Checker pattern select and result formatting.
// |floor| of each hit coordinate mod twice the square size, one restoring step
// per stage for both axes; depends on rgp_pkg.
`default_nettype none

module rgp_checker
  import rgp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      hit,
  input  wire logic [T_W-1:0]            t,
  input  wire logic signed [COORD_W-1:0] hx,
  input  wire logic signed [COORD_W-1:0] hz,
  input  wire logic                      checker_enable,
  input  wire logic [SQ_W-1:0]           tile_size,
  output logic                           done,
  output result_t                        result
);

  function automatic logic [ABS_W-1:0] abs_floor(input logic signed [COORD_W-1:0] v);
    logic [COORD_W:0] mag;
    logic [COORD_W:0] rnd;
    begin
      mag = v[COORD_W-1] ? (COORD_W+1)'(-(33'(v))) : (COORD_W+1)'(v);
      rnd = v[COORD_W-1] ? mag + (COORD_W+1)'(FRAC_MASK) : mag;
      abs_floor = ABS_W'(rnd >> COORD_FRAC_BITS);
    end
  endfunction

  function automatic logic [ABS_W-1:0] mod_step(input logic [ABS_W-1:0] r,
                                                input logic [PER_W-1:0] per,
                                                input int sh);
    logic [MOD_CMP_W-1:0] trial;
    logic [MOD_CMP_W-1:0] r_ext;
    begin
      trial = MOD_CMP_W'(per) << sh;
      r_ext = MOD_CMP_W'(r);
      mod_step = (r_ext >= trial) ? ABS_W'(r_ext - trial) : r;
    end
  endfunction

  chk_stage_t stg [0:MOD_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else begin
      stg[0].valid <= in_valid;
    end
    stg[0].hit <= hit;
    stg[0].en  <= checker_enable && (tile_size != '0);
    stg[0].t   <= t;
    stg[0].hx  <= hx;
    stg[0].hz  <= hz;
    stg[0].ax  <= abs_floor(hx);
    stg[0].az  <= abs_floor(hz);
    stg[0].per <= {tile_size, 1'b0};
  end

  for (genvar k = 1; k <= MOD_STEPS; k++) begin : g_mod
    localparam int SH = MOD_STEPS - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k].valid <= 1'b0;
      end else begin
        stg[k].valid <= stg[k-1].valid;
      end
      stg[k].hit <= stg[k-1].hit;
      stg[k].en  <= stg[k-1].en;
      stg[k].t   <= stg[k-1].t;
      stg[k].hx  <= stg[k-1].hx;
      stg[k].hz  <= stg[k-1].hz;
      stg[k].ax  <= mod_step(stg[k-1].ax, stg[k-1].per, SH);
      stg[k].az  <= mod_step(stg[k-1].az, stg[k-1].per, SH);
      stg[k].per <= stg[k-1].per;
    end
  end

  chk_stage_t           last;
  logic [MOD_CMP_W-1:0] half;
  logic                 fx;
  logic                 fz;
  result_t              res_next;

  assign last = stg[MOD_STEPS];
  assign half = MOD_CMP_W'(last.per >> 1);
  assign fx   = MOD_CMP_W'(last.ax) >= half;
  assign fz   = MOD_CMP_W'(last.az) >= half;

  always_comb begin
    res_next = '0;
    if (last.hit) begin
      res_next.hit             = 1'b1;
      res_next.hit_distance    = last.t;
      res_next.hit_x           = last.hx;
      res_next.hit_z           = last.hz;
      res_next.material_select = last.en & (fx ^ fz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    result <= res_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ray_ground_plane_checker_hit.sv -----
// Ray against horizontal ground plane with checkerboard material select.
// Takes one ray per clock (start while busy is low); busy is high during reset
// and in the cycle after it. Each ray gives exactly one result, strobed by done
// for a single cycle. At Q16.16 the path has 1 input stage, 32 divider stages
// (an overflow check, then one quotient bit each), 2 multiply/add stages and
// 17 checker stages (floor, 15 modulo steps, output register). The receiver
// cannot stall; results are never held.
// Configuration writes take effect at once and are meant for idle periods.
// Depends on rgp_pkg, rgp_div, rgp_advance and rgp_checker.
`default_nettype none

module ray_ground_plane_checker_hit
  import rgp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ray_t                  ray,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       done,
  output result_t                    result
);

  logic signed [COORD_W-1:0] plane_height;
  logic                      checker_enable;
  logic [SQ_W-1:0]           tile_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_height   <= '0;
      checker_enable <= 1'b0;
      tile_size      <= SQ_W'(1);
      busy           <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PLANE_HEIGHT:   plane_height   <= signed'(cfg_data[COORD_W-1:0]);
          CFG_CHECKER_ENABLE: checker_enable <= cfg_data[0];
          CFG_TILE_SIZE:      tile_size      <= cfg_data[SQ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // input stage: hit test and divider operands
  logic                      accept;
  logic signed [COORD_W:0]   diff;
  logic                      hit_in;
  logic                      in_valid;
  logic [COORD_W-1:0]        num;
  logic [COORD_W-1:0]        den;
  side_t                     side;

  assign accept = start && !busy;
  assign diff   = (COORD_W+1)'(ray.origin_y) - (COORD_W+1)'(plane_height);
  assign hit_in = (ray.origin_y > plane_height) && ray.dir_y[COORD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    num           <= diff[COORD_W-1:0];
    den           <= COORD_W'(-ray.dir_y);
    side.hit      <= hit_in;
    side.origin_x <= ray.origin_x;
    side.origin_z <= ray.origin_z;
    side.dir_x    <= ray.dir_x;
    side.dir_z    <= ray.dir_z;
  end

  logic           div_valid;
  logic [T_W-1:0] div_t;
  side_t          div_side;

  rgp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .num       (num),
    .den       (den),
    .in_side   (side),
    .out_valid (div_valid),
    .t         (div_t),
    .out_side  (div_side)
  );

  logic signed [COORD_W-1:0] hx;
  logic signed [COORD_W-1:0] hz;

  rgp_advance u_adv_x (
    .clk (clk),
    .org (div_side.origin_x),
    .dir (div_side.dir_x),
    .t   (div_t),
    .pos (hx)
  );

  rgp_advance u_adv_z (
    .clk (clk),
    .org (div_side.origin_z),
    .dir (div_side.dir_z),
    .t   (div_t),
    .pos (hz)
  );

  // match the two advance stages
  logic           adv_valid1, adv_valid2;
  logic           adv_hit1, adv_hit2;
  logic [T_W-1:0] adv_t1, adv_t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      adv_valid1 <= 1'b0;
      adv_valid2 <= 1'b0;
    end else begin
      adv_valid1 <= div_valid;
      adv_valid2 <= adv_valid1;
    end
    adv_hit1 <= div_side.hit;
    adv_hit2 <= adv_hit1;
    adv_t1   <= div_t;
    adv_t2   <= adv_t1;
  end

  rgp_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (adv_valid2),
    .hit            (adv_hit2),
    .t              (adv_t2),
    .hx             (hx),
    .hz             (hz),
    .checker_enable (checker_enable),
    .tile_size      (tile_size),
    .done           (done),
    .result         (result)
  );

endmodule

`default_nettype wire
